FILE: rtl/ple_pkg.sv
package ple_pkg;

   localparam int DEPTH_DEF = 16;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_READ_FWD = 2'd2,
      OP_READ_REV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RSP_OK      = 2'd0,
      RSP_BAD_POS = 2'd1,
      RSP_FULL    = 2'd2,
      RSP_EMPTY   = 2'd3
   } rsp_status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic single;
      logic read_step;
   } ple_cmd_type;

   typedef struct packed {
      logic out_free;
      logic read_nonempty;
      logic read_last;
   } ple_stat_type;

endpackage

FILE: rtl/ple_ctrl.sv
module ple_ctrl import ple_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ple_stat_type stat,
   output ple_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            if (stat.out_free) begin
               if (!stat.read_nonempty || stat.read_last) begin
                  state_in = CTL_IDLE;
               end
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.single    = 1'b0;
      cmd.read_step = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         CTL_EXEC: begin
            if (stat.out_free) begin
               cmd.read_step = stat.read_nonempty;
               cmd.single    = !stat.read_nonempty;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/ple_datapath.sv
module ple_datapath import ple_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   input  ple_cmd_type        cmd,
   output ple_stat_type       stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value_res,
   output logic [4:0]         rsp_count,
   output logic               rsp_last
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

   op_type             op_ff;
   logic signed [31:0] value_ff;
   logic [4:0]         position_ff;

   logic signed [31:0] cells_ff [DEPTH];
   logic signed [31:0] cells_in [DEPTH];
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_status_type     rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [CMPW-1:0]    pos_x, cnt_x, ci;
   logic [IW-1:0]      rd_addr;
   logic               is_read;

   assign pos_x   = CMPW'(position_ff);
   assign cnt_x   = CMPW'(count_ff);
   assign is_read = (op_ff == OP_READ_FWD) || (op_ff == OP_READ_REV);
   assign rd_addr = (op_ff == OP_READ_FWD) ? idx_ff
                                           : IW'(count_ff - CW'(1) - CW'(idx_ff));

   assign stat.out_free      = !rsp_valid_ff || rsp_ready;
   assign stat.read_nonempty = is_read && (count_ff != '0);
   assign stat.read_last     = (CW'(idx_ff) + CW'(1)) == count_ff;

   always_comb begin
      cells_in      = cells_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      ci            = '0;
      rsp_status_in = RSP_OK;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      if (cmd.capture) begin
         idx_in = '0;
      end
      if (cmd.single) begin
         case (op_ff)
            OP_INSERT: begin
               if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                  rsp_status_in = RSP_BAD_POS;
               end else if (cnt_x >= CMPW'(DEPTH)) begin
                  rsp_status_in = RSP_FULL;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     ci = CMPW'(i);
                     if (ci == pos_x - CMPW'(1)) begin
                        cells_in[i] = value_ff;
                     end else if (ci >= pos_x && ci <= cnt_x) begin
                        cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
                     end
                  end
                  count_in = count_ff + CW'(1);
               end
            end
            OP_DELETE: begin
               if (count_ff == '0) begin
                  rsp_status_in = RSP_EMPTY;
               end else if (pos_x == '0 || pos_x > cnt_x) begin
                  rsp_status_in = RSP_BAD_POS;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     ci = CMPW'(i);
                     if (ci >= pos_x - CMPW'(1) && i < DEPTH - 1) begin
                        cells_in[i] = cells_ff[(i < DEPTH - 1) ? i + 1 : i];
                     end
                  end
                  count_in = count_ff - CW'(1);
               end
            end
            default: rsp_status_in = RSP_EMPTY;
         endcase
      end
      if (cmd.read_step) begin
         rsp_value_in = cells_ff[rd_addr];
         rsp_last_in  = stat.read_last;
         idx_in       = idx_ff + IW'(1);
      end
      rsp_count_in = 5'(count_in);
      if (cmd.single || cmd.read_step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      if (cmd.capture) begin
         op_ff       <= op_type'(req_op);
         value_ff    <= req_value;
         position_ff <= req_position;
      end
      if (cmd.single || cmd.read_step) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: rtl/positional_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit values, 1-based positions.
// Request channel (req_valid/req_ready): op, value, position. Ops are
// insert, delete, read forward and read reverse.
// Response channel (rsp_valid/rsp_ready): status, value_res, count, last.
// Insert and delete give one response; a read gives one response per
// entry (last on the final one), or one empty-status response.
// Each request is captured into the op, value and position registers;
// the execute state then loads the response register once any pending
// response has been taken. An insert or delete has a capture step and
// an execute step that shifts every cell in parallel. A read returns
// one entry per cycle while rsp_ready is high, via the output register.
// A new request is taken once the previous operation has loaded its last
// response, even while that response still waits for rsp_ready.
// When the receiver stalls, the engine holds the pending response and
// pauses until it is taken.
// Reset empties the list and clears the response valid; cell contents
// are not cleared and are only read below the entry count.
module positional_list_engine import ple_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value_res,
   output logic [4:0]         rsp_count,
   output logic               rsp_last
);

   ple_cmd_type  cmd;
   ple_stat_type stat;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ple_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_position  (req_position),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_res (rsp_value_res),
      .rsp_count     (rsp_count),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: verif/tb_positional_list_engine.sv
module tb_positional_list_engine;
   import ple_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 300000;
   localparam int FILL_AT = 12;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_res;
      logic [4:0]         count;
      logic               last;
   } list_rsp_t;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
      logic [4:0]         pos;
      logic               fixed_exp;
      rsp_status_type     status;
      logic [4:0]         count;
   } list_req_t;

   // fixed_exp rows carry their single response; the rest go through the list model
   localparam list_req_t DIR_ROWS [17] = '{
      '{OP_READ_FWD, 32'sd0,           5'd0,  1'b1, RSP_EMPTY,   5'd0},
      '{OP_READ_REV, 32'sd0,           5'd31, 1'b1, RSP_EMPTY,   5'd0},
      '{OP_DELETE,   32'sd0,           5'd1,  1'b1, RSP_EMPTY,   5'd0},
      '{OP_INSERT,   32'sd0,           5'd0,  1'b1, RSP_BAD_POS, 5'd0},
      '{OP_INSERT,   32'sd5,           5'd2,  1'b1, RSP_BAD_POS, 5'd0},
      '{OP_INSERT,   32'sh7FFFFFFF,    5'd1,  1'b1, RSP_OK,      5'd1},
      '{OP_INSERT,   32'sh80000000,    5'd1,  1'b1, RSP_OK,      5'd2},
      '{OP_INSERT,   32'shFFFFFFFF,    5'd3,  1'b1, RSP_OK,      5'd3},
      '{OP_READ_REV, 32'sd0,           5'd0,  1'b0, RSP_OK,      5'd0},
      '{OP_DELETE,   32'sd0,           5'd0,  1'b1, RSP_BAD_POS, 5'd3},
      '{OP_DELETE,   32'sd0,           5'd4,  1'b1, RSP_BAD_POS, 5'd3},
      '{OP_DELETE,   32'sd0,           5'd3,  1'b1, RSP_OK,      5'd2},
      '{OP_INSERT,   32'sd9,           5'd17, 1'b1, RSP_FULL,    5'd16},
      '{OP_INSERT,   32'sd9,           5'd18, 1'b1, RSP_BAD_POS, 5'd16},
      '{OP_READ_FWD, 32'sd0,           5'd0,  1'b0, RSP_OK,      5'd0},
      '{OP_DELETE,   32'sd0,           5'd31, 1'b1, RSP_BAD_POS, 5'd16},
      '{OP_DELETE,   32'sd0,           5'd1,  1'b1, RSP_OK,      5'd15}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op = OP_INSERT;
   logic signed [31:0] req_value = '0;
   logic [4:0]         req_position = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_value_res;
   logic [4:0]         rsp_count;
   logic               rsp_last;

   logic signed [31:0] list_cells [LIST_DEPTH];
   int                 list_len = 0;
   list_rsp_t          predicted[$];
   list_rsp_t          expected_rsps[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int reqs_sent = 0;
   int rsps_checked = 0;
   int full_seen = 0;
   int empty_seen = 0;
   int cycle_count = 0;

   positional_list_engine #(.DEPTH(LIST_DEPTH)) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_res (rsp_value_res),
      .rsp_count     (rsp_count),
      .rsp_last      (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void push_status(rsp_status_type status);
      predicted.push_back('{status: status, value_res: 32'sd0,
                            count: list_len[4:0], last: 1'b1});
   endfunction

   function automatic void predict_list_op(op_type op, logic signed [31:0] value,
                                           logic [4:0] pos);
      int i;
      int idx;
      predicted.delete();
      case (op)
         OP_INSERT: begin
            if (pos == 0 || pos > list_len + 1) begin
               push_status(RSP_BAD_POS);
            end else if (list_len >= LIST_DEPTH) begin
               push_status(RSP_FULL);
            end else begin
               for (i = list_len; i >= pos; i--)
                  list_cells[i] = list_cells[i - 1];
               list_cells[pos - 1] = value;
               list_len++;
               push_status(RSP_OK);
            end
         end
         OP_DELETE: begin
            if (list_len == 0) begin
               push_status(RSP_EMPTY);
            end else if (pos == 0 || pos > list_len) begin
               push_status(RSP_BAD_POS);
            end else begin
               for (i = pos - 1; i + 1 < list_len; i++)
                  list_cells[i] = list_cells[i + 1];
               list_len--;
               push_status(RSP_OK);
            end
         end
         default: begin
            if (list_len == 0) begin
               push_status(RSP_EMPTY);
            end else begin
               for (i = 0; i < list_len; i++) begin
                  idx = (op == OP_READ_FWD) ? i : list_len - 1 - i;
                  predicted.push_back('{status: RSP_OK, value_res: list_cells[idx],
                                        count: list_len[4:0],
                                        last: (i + 1 == list_len)});
               end
            end
         end
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the request transfers.
   task automatic send_req(list_req_t item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_op       <= item.op;
      req_value    <= item.value;
      req_position <= item.pos;
      do @(posedge clock); while (!req_ready);
      reqs_sent++;
      predict_list_op(item.op, item.value, item.pos);
      if (predicted[0].status == RSP_FULL) full_seen++;
      if (predicted[0].status == RSP_EMPTY) empty_seen++;
      if (item.fixed_exp) begin
         expected_rsps.push_back('{status: item.status, value_res: 32'sd0,
                                   count: item.count, last: 1'b1});
      end else begin
         foreach (predicted[k]) expected_rsps.push_back(predicted[k]);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(int n_items, int send_pct, int recv_pct);
      list_req_t item;
      logic      fill_bias;
      int        r;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      fill_bias = 1'b1;
      for (int n = 0; n < n_items; n++) begin
         if (n % 32 == 0) fill_bias = 1'($urandom_range(1));
         item = '{OP_INSERT, 32'sd0, 5'd0, 1'b0, RSP_OK, 5'd0};
         r = $urandom_range(99);
         case ($urandom_range(7))
            0: item.value = 32'sh7FFFFFFF;
            1: item.value = 32'sh80000000;
            default: item.value = $urandom;
         endcase
         if (r < 8) begin
            item.op  = op_type'($urandom_range(3));
            item.pos = 5'($urandom_range(31));
         end else begin
            r = $urandom_range(99);
            if (r < 25)
               item.op = $urandom_range(1) ? OP_READ_FWD : OP_READ_REV;
            else if (r < (fill_bias ? 80 : 45))
               item.op = OP_INSERT;
            else
               item.op = OP_DELETE;
            if ($urandom_range(9) == 0)
               item.pos = 5'($urandom_range(31));
            else if (item.op == OP_INSERT)
               item.pos = 5'($urandom_range(list_len + 1, 1));
            else if (list_len > 0)
               item.pos = 5'($urandom_range(list_len, 1));
            else
               item.pos = 5'($urandom_range(31));
         end
         send_req(item);
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      list_rsp_t got;
      list_rsp_t exp;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{status: rsp_status, value_res: rsp_value_res,
                 count: rsp_count, last: rsp_last};
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected rsp transfer: status %0d value %0d count %0d last %0d",
                     $time, got.status, got.value_res, got.count, got.last);
            error_count++;
         end else begin
            exp = expected_rsps.pop_front();
            rsps_checked++;
            if (got !== exp) begin
               $display("%0t: rsp mismatch: expected status %0d value %0d count %0d last %0d",
                        $time, exp.status, exp.value_res, exp.count, exp.last);
               $display("%0t: rsp mismatch: actual status %0d value %0d count %0d last %0d",
                        $time, got.status, got.value_res, got.count, got.last);
               error_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_rsps.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      recv_idle_pct = 30;
      for (int i = 0; i < $size(DIR_ROWS); i++) begin
         if (i == FILL_AT) begin
            while (list_len < LIST_DEPTH)
               send_req('{OP_INSERT, $urandom, 5'($urandom_range(list_len + 1, 1)),
                          1'b0, RSP_OK, 5'd0});
         end
         send_req(DIR_ROWS[i]);
      end
      wait_drained();

      random_phase(165, 37, 58);
      random_phase(165, 58, 37);
      random_phase(170, 0, 0);

      recv_idle_pct = 0;
      repeat (20) @(posedge clock);

      $display("Ran %0d requests, checked %0d responses", reqs_sent, rsps_checked);
      $display("List-full rejects: %0d, empty-list responses: %0d", full_seen, empty_seen);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: positional_list_engine.f
rtl/ple_pkg.sv
rtl/ple_ctrl.sv
rtl/ple_datapath.sv
rtl/positional_list_engine.sv
verif/tb_positional_list_engine.sv
